[sv/ipv6ptf_pkg.sv]
package ipv6ptf_pkg;

    localparam int NUM_WORDS = 8;
    localparam int NUM_SEGS  = 9;

    // A segment is one shown word, or the prefix suffix in the last slot.
    localparam logic [3:0] SEG_SUFFIX = 4'd8;

    localparam logic [1:0] KIND_COLONS = 2'd0;
    localparam logic [1:0] KIND_HEX    = 2'd1;
    localparam logic [1:0] KIND_V4     = 2'd2;
    localparam logic [1:0] KIND_SUFFIX = 2'd3;

    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_LO = 8'h57;

    localparam logic [7:0] MAX_PREFIX   = 8'd128;
    localparam logic [7:0] V4_FULL_BITS = 8'd120;
    localparam logic [7:0] BYTE_ALL     = 8'hff;

    typedef logic [NUM_WORDS-1:0][15:0] words_t;

    typedef struct packed {
        words_t                     wd;
        logic [NUM_SEGS-1:0][1:0]   kind;
        logic [NUM_SEGS-1:0][3:0]   seg_len;
        logic [NUM_WORDS-1:0][2:0]  hexcnt;
        logic [1:0][1:0][11:0]      v4dig;
        logic [1:0][1:0][1:0]       v4n;
        logic [11:0]                bitsdig;
        logic [1:0]                 bitsn;
        logic [5:0]                 total;
        logic                       rej;
    } fmt_t;

    typedef struct packed {
        words_t      wd;
        logic [7:0]  bits;
        logic [7:0]  cap;
        logic        err;
    } s1_t;

    typedef struct packed {
        words_t      wd;
        logic [7:0]  bits;
        logic [7:0]  cap;
        logic        err;
        logic [3:0]  words;
        logic [2:0]  bp;
        logic [3:0]  bl;
        logic        v4;
    } s2_t;

    typedef struct packed {
        fmt_t        fmt;
        logic [7:0]  cap;
        logic        err;
    } s3_t;

    function automatic logic [2:0] hex_len(input logic [15:0] w);
        logic [2:0] n;
        if (w[15:12] != 4'd0) n = 3'd4;
        else if (w[11:8] != 4'd0) n = 3'd3;
        else if (w[7:4] != 4'd0) n = 3'd2;
        else n = 3'd1;
        return n;
    endfunction

    function automatic logic [1:0] dec_len(input logic [7:0] v);
        logic [1:0] n;
        if (v >= 8'd100) n = 2'd3;
        else if (v >= 8'd10) n = 2'd2;
        else n = 2'd1;
        return n;
    endfunction

    // Returns hundreds, tens and ones as three nibbles; tens by reciprocal.
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        if (v >= 8'd200) h = 2'd2;
        else if (v >= 8'd100) h = 2'd1;
        else h = 2'd0;
        r = v - 8'(h * 8'd100);
        prod = {8'd0, r} * 16'd205;
        t = prod[14:11];
        o = r - 8'(t * 8'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

    function automatic logic [7:0] dec_char(input logic [11:0] digs, input logic [1:0] n,
                                            input logic [1:0] idx);
        logic [1:0] p;
        logic [3:0] base;
        p = idx + 2'd3 - n;
        base = 4'd11 - {p, 2'b00};
        return CH_ZERO + {4'd0, digs[base -: 4]};
    endfunction

endpackage

[sv/ipv6ptf_in_if.sv]
interface ipv6ptf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_bits;
    logic [7:0]  dest_capacity;

    modport source (output valid, address_high, address_low, prefix_bits, dest_capacity,
                    input ready);
    modport sink (input valid, address_high, address_low, prefix_bits, dest_capacity,
                  output ready);
endinterface

[sv/ipv6ptf_out_if.sv]
interface ipv6ptf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_valid;
    logic       last;
    logic [5:0] text_length;

    modport source (output valid, char_code, char_valid, last, text_length, input ready);
    modport sink (input valid, char_code, char_valid, last, text_length, output ready);
endinterface

[sv/ipv6_prefix_text_formatter.sv]
// Path: an input transfer passes the four pipeline stages, the emitter load and the
// output register before its first character appears on the output.
// Throughput: one character per cycle on the output unless out_ch.ready stalls it;
// an item gives its text length in characters, or one empty result if rejected.
// Items enter back to back into the four stages while the character emitter works.
// Reset (rst_n low, asynchronous) empties all stages and the output register.
module ipv6_prefix_text_formatter (
    input  logic                 clk,
    input  logic                 rst_n,
    ipv6ptf_in_if.sink           in_ch,
    ipv6ptf_out_if.source        out_ch
);

    // Stage valid bits and payload.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ipv6ptf_pkg::s1_t  s1_reg, s1_next;
    ipv6ptf_pkg::s2_t  s2_reg, s2_next;
    ipv6ptf_pkg::s3_t  s3_reg, s3_next;
    ipv6ptf_pkg::fmt_t s4_reg, s4_next;

    logic ld1, ld2, ld3, ld4;
    logic em_free;

    // Emitter state.
    logic              act_reg, act_next;
    ipv6ptf_pkg::fmt_t em_reg;
    logic [3:0]        seg_reg, seg_next;
    logic [3:0]        off_reg, off_next;
    logic [5:0]        cnt_reg, cnt_next;

    logic       ov_reg, ov_next;
    logic [7:0] oc_reg;
    logic       ocv_reg;
    logic       olast_reg;
    logic [5:0] olen_reg;

    logic       fire, take, cur_last;
    logic [7:0] ch;
    logic [3:0] first_seg, nxt_seg;

    assign ld4 = !v4_reg || em_free;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_ch.ready = ld1;

    // Stage 1: clear host bits and split into words.
    always_comb
    begin
        logic [127:0] mask;
        logic [127:0] addr;
        if (in_ch.prefix_bits >= ipv6ptf_pkg::MAX_PREFIX)
            mask = '1;
        else
            mask = ~({128{1'b1}} >> in_ch.prefix_bits[6:0]);
        addr = {in_ch.address_high, in_ch.address_low} & mask;
        for (int k = 0; k < ipv6ptf_pkg::NUM_WORDS; k++)
        begin
            s1_next.wd[k] = addr[127 - 16 * k -: 16];
        end
        s1_next.bits = in_ch.prefix_bits;
        s1_next.cap  = in_ch.dest_capacity;
        s1_next.err  = in_ch.prefix_bits > ipv6ptf_pkg::MAX_PREFIX;
    end

    // Stage 2: shown word count, longest zero run, dotted tail decision.
    always_comb
    begin
        logic [8:0] wsum;
        logic [3:0] words;
        logic [2:0] cur_pos, long_pos;
        logic [3:0] cur_len, long_len;
        logic       v4;
        wsum = {1'b0, s1_reg.bits} + 9'd15;
        words = (wsum[8:4] < 5'd2) ? 4'd2 : wsum[7:4];
        cur_pos = '0;
        long_pos = '0;
        cur_len = '0;
        long_len = '0;
        for (int k = 0; k < ipv6ptf_pkg::NUM_WORDS; k++)
        begin
            if (4'(k) < words)
            begin
                if (s1_reg.wd[k] == 16'd0)
                begin
                    if (cur_len == 4'd0) cur_pos = 3'(k);
                    cur_len = cur_len + 4'd1;
                end
                else
                begin
                    if (long_len < cur_len)
                    begin
                        long_pos = cur_pos;
                        long_len = cur_len;
                    end
                    cur_len = 4'd0;
                end
            end
        end
        if (long_len < cur_len)
        begin
            long_pos = cur_pos;
            long_len = cur_len;
        end
        v4 = 1'b0;
        if (long_len != words && long_pos == 3'd0)
        begin
            if (long_len == 4'd6)
                v4 = 1'b1;
            else if (long_len == 4'd5 && s1_reg.wd[5] == {ipv6ptf_pkg::BYTE_ALL,
                                                          ipv6ptf_pkg::BYTE_ALL})
                v4 = 1'b1;
            else if (long_len == 4'd7 && s1_reg.wd[7] != 16'd1)
            begin
                v4 = 1'b1;
                long_len = 4'd6;
            end
        end
        s2_next.wd    = s1_reg.wd;
        s2_next.bits  = s1_reg.bits;
        s2_next.cap   = s1_reg.cap;
        s2_next.err   = s1_reg.err;
        s2_next.words = words;
        s2_next.bp    = long_pos;
        s2_next.bl    = long_len;
        s2_next.v4    = v4;
    end

    // Stage 3: digits and the character count of every segment.
    always_comb
    begin
        logic [3:0] run_end;
        logic       in_run;
        logic       incl;
        logic [1:0] nh, nl;
        run_end = {1'b0, s2_reg.bp} + s2_reg.bl;
        s3_next = '0;
        s3_next.fmt.wd = s2_reg.wd;
        s3_next.cap = s2_reg.cap;
        s3_next.err = s2_reg.err;
        for (int j = 0; j < 2; j++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                s3_next.fmt.v4dig[j][b] =
                    ipv6ptf_pkg::dec_digits(s2_reg.wd[6 + j][15 - 8 * b -: 8]);
                s3_next.fmt.v4n[j][b] =
                    ipv6ptf_pkg::dec_len(s2_reg.wd[6 + j][15 - 8 * b -: 8]);
            end
        end
        s3_next.fmt.bitsdig = ipv6ptf_pkg::dec_digits(s2_reg.bits);
        s3_next.fmt.bitsn   = ipv6ptf_pkg::dec_len(s2_reg.bits);
        for (int k = 0; k < ipv6ptf_pkg::NUM_WORDS; k++)
        begin
            s3_next.fmt.hexcnt[k] = ipv6ptf_pkg::hex_len(s2_reg.wd[k]);
            in_run = s2_reg.bl > 4'd1 && 4'(k) >= {1'b0, s2_reg.bp} && 4'(k) < run_end;
            incl = (k != 7) || (s2_reg.bits > ipv6ptf_pkg::V4_FULL_BITS);
            nh = s3_next.fmt.v4n[k % 2][0];
            nl = s3_next.fmt.v4n[k % 2][1];
            s3_next.fmt.kind[k] = ipv6ptf_pkg::KIND_HEX;
            if (4'(k) >= s2_reg.words)
            begin
                s3_next.fmt.seg_len[k] = 4'd0;
            end
            else if (in_run)
            begin
                s3_next.fmt.kind[k] = ipv6ptf_pkg::KIND_COLONS;
                s3_next.fmt.seg_len[k] = {3'd0, 4'(k) == {1'b0, s2_reg.bp}}
                                       + {3'd0, 4'(k) == s2_reg.words - 4'd1};
            end
            else if (s2_reg.v4 && k > 5)
            begin
                s3_next.fmt.kind[k] = ipv6ptf_pkg::KIND_V4;
                s3_next.fmt.seg_len[k] = 4'd1 + {2'd0, nh}
                                       + (incl ? 4'd1 + {2'd0, nl} : 4'd0);
            end
            else
            begin
                s3_next.fmt.seg_len[k] = {3'd0, k > 0} + {1'b0, s3_next.fmt.hexcnt[k]};
            end
        end
        s3_next.fmt.kind[ipv6ptf_pkg::SEG_SUFFIX] = ipv6ptf_pkg::KIND_SUFFIX;
        if (s2_reg.bits == 8'd0)
        begin
            // A zero prefix is just the double colon.
            for (int k = 1; k < ipv6ptf_pkg::NUM_SEGS; k++)
            begin
                s3_next.fmt.seg_len[k] = 4'd0;
            end
            s3_next.fmt.kind[0] = ipv6ptf_pkg::KIND_COLONS;
            s3_next.fmt.seg_len[0] = 4'd2;
        end
        else if (s2_reg.bits == ipv6ptf_pkg::MAX_PREFIX)
            s3_next.fmt.seg_len[ipv6ptf_pkg::SEG_SUFFIX] = 4'd0;
        else
            s3_next.fmt.seg_len[ipv6ptf_pkg::SEG_SUFFIX] = 4'd1 + {2'd0, s3_next.fmt.bitsn};
    end

    // Stage 4: total length and the capacity check.
    always_comb
    begin
        logic [6:0] tot;
        tot = '0;
        for (int s = 0; s < ipv6ptf_pkg::NUM_SEGS; s++)
        begin
            tot = tot + {3'd0, s3_reg.fmt.seg_len[s]};
        end
        s4_next = s3_reg.fmt;
        s4_next.total = tot[5:0];
        s4_next.rej = s3_reg.err || ({1'b0, tot} >= s3_reg.cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_ch.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1) s1_reg <= s1_next;
        if (ld2) s2_reg <= s2_next;
        if (ld3) s3_reg <= s3_next;
        if (ld4) s4_reg <= s4_next;
    end

    // Character emitter.
    always_comb
    begin
        logic found_a, found_b;
        first_seg = ipv6ptf_pkg::SEG_SUFFIX;
        nxt_seg = ipv6ptf_pkg::SEG_SUFFIX;
        found_a = 1'b0;
        found_b = 1'b0;
        for (int s = 0; s < ipv6ptf_pkg::NUM_SEGS; s++)
        begin
            if (!found_a && s4_reg.seg_len[s] != 4'd0)
            begin
                first_seg = 4'(s);
                found_a = 1'b1;
            end
            if (!found_b && 4'(s) > seg_reg && em_reg.seg_len[s] != 4'd0)
            begin
                nxt_seg = 4'(s);
                found_b = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [15:0] w;
        logic [2:0]  hn;
        logic        lead;
        logic [2:0]  idx;
        logic [1:0]  p;
        logic [3:0]  base;
        logic [3:0]  nib;
        logic        j;
        logic [1:0]  nh, nl;
        w = em_reg.wd[seg_reg[2:0]];
        hn = em_reg.hexcnt[seg_reg[2:0]];
        lead = seg_reg != 4'd0;
        idx = off_reg[2:0] - {2'd0, lead};
        p = 2'(idx + (3'd4 - hn));
        base = 4'd15 - {p, 2'b00};
        nib = w[base -: 4];
        j = seg_reg[0];
        nh = em_reg.v4n[j][0];
        nl = em_reg.v4n[j][1];
        case (em_reg.kind[seg_reg])
            ipv6ptf_pkg::KIND_COLONS:
                ch = ipv6ptf_pkg::CH_COLON;
            ipv6ptf_pkg::KIND_HEX:
            begin
                if (lead && off_reg == 4'd0)
                    ch = ipv6ptf_pkg::CH_COLON;
                else if (nib < 4'd10)
                    ch = ipv6ptf_pkg::CH_ZERO + {4'd0, nib};
                else
                    ch = ipv6ptf_pkg::CH_HEX_LO + {4'd0, nib};
            end
            ipv6ptf_pkg::KIND_V4:
            begin
                if (off_reg == 4'd0)
                    ch = (seg_reg == 4'd6) ? ipv6ptf_pkg::CH_COLON : ipv6ptf_pkg::CH_DOT;
                else if (off_reg <= {2'd0, nh})
                    ch = ipv6ptf_pkg::dec_char(em_reg.v4dig[j][0], nh, 2'(off_reg - 4'd1));
                else if (off_reg == {2'd0, nh} + 4'd1)
                    ch = ipv6ptf_pkg::CH_DOT;
                else
                    ch = ipv6ptf_pkg::dec_char(em_reg.v4dig[j][1], nl,
                                               2'(off_reg - {2'd0, nh} - 4'd2));
            end
            ipv6ptf_pkg::KIND_SUFFIX:
            begin
                if (off_reg == 4'd0)
                    ch = ipv6ptf_pkg::CH_SLASH;
                else
                    ch = ipv6ptf_pkg::dec_char(em_reg.bitsdig, em_reg.bitsn,
                                               2'(off_reg - 4'd1));
            end
            default:
                ch = ipv6ptf_pkg::CH_COLON;
        endcase
    end

    assign fire = act_reg && (!ov_reg || out_ch.ready);
    assign cur_last = em_reg.rej || (cnt_reg + 6'd1 == em_reg.total);
    assign em_free = !act_reg || (fire && cur_last);
    assign take = em_free && v4_reg;

    always_comb
    begin
        act_next = act_reg;
        seg_next = seg_reg;
        off_next = off_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            act_next = 1'b1;
            seg_next = first_seg;
            off_next = 4'd0;
            cnt_next = 6'd0;
        end
        else if (fire)
        begin
            if (cur_last)
                act_next = 1'b0;
            cnt_next = cnt_reg + 6'd1;
            if (off_reg + 4'd1 == em_reg.seg_len[seg_reg])
            begin
                seg_next = nxt_seg;
                off_next = 4'd0;
            end
            else
                off_next = off_reg + 4'd1;
        end
        if (fire)
            ov_next = 1'b1;
        else if (out_ch.ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ov_reg <= 1'b0;
            seg_reg <= '0;
            off_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            ov_reg <= ov_next;
            seg_reg <= seg_next;
            off_reg <= off_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            em_reg <= s4_reg;
        if (fire)
        begin
            oc_reg <= em_reg.rej ? 8'd0 : ch;
            ocv_reg <= !em_reg.rej;
            olast_reg <= cur_last;
            olen_reg <= em_reg.rej ? 6'd0 : em_reg.total;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.char_code   = oc_reg;
    assign out_ch.char_valid  = ocv_reg;
    assign out_ch.last        = olast_reg;
    assign out_ch.text_length = olen_reg;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.char_valid |-> out_ch.last && out_ch.text_length == 6'd0)
        else $error("empty result without last or with nonzero length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg && !em_reg.rej |-> cnt_reg < em_reg.total)
        else $error("character count ran past the text length");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cur_last |=> act_reg && ov_reg)
        else $error("emitter stopped before the last character");

endmodule
